// File: rtl/core/timestamp_merge_with_interval_stats_defines.svh
// Assertion macros shared by the merge block's checking code.
`ifndef TIMESTAMP_MERGE_WITH_INTERVAL_STATS_DEFINES_SVH
`define TIMESTAMP_MERGE_WITH_INTERVAL_STATS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TMIS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TMIS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/tmis_pkg.sv
// Types, constants and codes of the timestamp merge block.
package tmis_pkg;

	localparam int NUM_QUEUES  = 2;
	localparam int QUEUE_DEPTH = 16;
	localparam int STAMP_BITS  = 32;

	localparam int QSEL_W = 1;
	localparam int POS_W  = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = POS_W + 1;
	localparam int SLOTS  = NUM_QUEUES * QUEUE_DEPTH;
	localparam int ADDR_W = $clog2(SLOTS);
	localparam int QUSE_W = 2;
	localparam int DIV_STEPS = 64;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [31:0] STAMP_MASK = 32'((64'd1 << STAMP_BITS) - 64'd1);
	localparam logic [QUSE_W-1:0] QUEUES_RESET = QUSE_W'(2);

	localparam logic [1:0] FUNC_PUSH   = 2'd0;
	localparam logic [1:0] FUNC_POP    = 2'd1;
	localparam logic [1:0] FUNC_REWIND = 2'd2;

	localparam logic [2:0] STAT_PUSHED    = 3'd0;
	localparam logic [2:0] STAT_DROPPED   = 3'd1;
	localparam logic [2:0] STAT_DELIVERED = 3'd2;
	localparam logic [2:0] STAT_NONE      = 3'd3;
	localparam logic [2:0] STAT_REWOUND   = 3'd4;

	typedef struct packed {
		logic [1:0]        func;
		logic [QSEL_W-1:0] queue_select;
		logic [31:0]       stamp;
		logic [31:0]       source_stamp;
		logic              is_positioning;
		logic [31:0]       payload;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [QSEL_W-1:0] from_queue;
		logic [31:0]       out_stamp;
		logic [31:0]       out_payload;
		logic signed [31:0] interval;
		logic signed [31:0] mean_interval;
		logic [30:0]       peak_interval;
		logic signed [31:0] fix_delay;
	} out_item_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] stamp;
		logic [31:0] source_stamp;
		logic [31:0] payload;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic exec_simple;
		logic rd_q0;
		logic rd_q1;
		logic cap_h0;
		logic select;
		logic mul;
		logic num;
		logic div_start;
		logic mean_wr;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_pop;
		logic pop_ready;
		logic two_q;
		logic div_done;
	} dp_status_t;

endpackage

// File: rtl/core/tmis_ifs.sv
// Stream channel interfaces for input items and result items.
interface tmis_in_if import tmis_pkg::*; ;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tmis_out_if import tmis_pkg::*; ;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/timestamp_merge_with_interval_stats.sv
// Top level of the timestamp merge with interval statistics.
// Merges two timestamped queues of 16 entries each in time order and returns one result per
// item. A pop that delivers runs through the 64-step shift-subtract divider that forms the
// running mean; all other items skip it. One item is in work at a time; a finished result
// waits in the output register while the next item is taken. queues_in_use is to be written
// through cfg_we/cfg_wdata only while idle; the block itself does not enforce this.
module timestamp_merge_with_interval_stats import tmis_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [QUSE_W-1:0] cfg_wdata,
	tmis_in_if.sink           in_ch,
	tmis_out_if.source        out_ch
);

`include "timestamp_merge_with_interval_stats_defines.svh"

	ctrl_cmd_t  cmd;
	dp_status_t st;

	tmis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.st        (st),
		.cmd       (cmd)
	);

	tmis_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_ch.data),
		.cmd       (cmd),
		.st        (st),
		.out_data  (out_ch.data)
	);

	`TMIS_ASSERT_NEXT(a_one_item, in_ch.valid && in_ch.ready, !in_ch.ready, "second item taken while busy")
	`TMIS_ASSERT_IMPL(a_sel_heads, cmd.select, st.pop_ready, "merge select without unread heads")
	`TMIS_ASSERT_IMPL(a_peak_bound, out_ch.valid && out_ch.data.status == STAT_DELIVERED, $signed(out_ch.data.interval) <= $signed({1'b0, out_ch.data.peak_interval}), "interval above peak")

endmodule

// File: rtl/core/tmis_div.sv
// Restoring divider: signed 64-bit dividend by unsigned 32-bit count, one bit a cycle.
module tmis_div import tmis_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] dividend,
	input  logic [31:0]        divisor,
	output logic               done,
	output logic signed [31:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [31:0]          rem_q;
	logic [63:0]          quo_q;
	logic [31:0]          dvs_q;
	logic [32:0]          shifted;
	logic                 fits;

	assign shifted = {rem_q, quo_q[63]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[63];
			quo_q <= dividend[63] ? 64'(-dividend) : 64'(dividend);
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(shifted - {1'b0, dvs_q}) : shifted[31:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	// truncate toward zero: divide magnitudes, then restore the sign
	assign quotient = neg_q ? -$signed(quo_q[31:0]) : $signed(quo_q[31:0]);
	assign done     = done_q;

endmodule

// File: rtl/core/tmis_ctrl.sv
// Sequencer for push, pop and rewind items.
module tmis_ctrl import tmis_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t st,
	output ctrl_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_RD1   = 4'd2;
	localparam logic [3:0] S_SEL   = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_NUM   = 4'd5;
	localparam logic [3:0] S_DIVGO = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DEC;
				end
			end
			S_DEC: begin
				if (st.is_pop && st.pop_ready) begin
					cmd.rd_q0 = 1'b1;
					state_d   = S_RD1;
				end else begin
					cmd.exec_simple = 1'b1;
					state_d         = S_OUT;
				end
			end
			S_RD1: begin
				cmd.cap_h0 = 1'b1;
				cmd.rd_q1  = st.two_q;
				state_d    = S_SEL;
			end
			S_SEL: begin
				cmd.select = 1'b1;
				state_d    = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_NUM;
			end
			S_NUM: begin
				cmd.num = 1'b1;
				state_d = S_DIVGO;
			end
			S_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (st.div_done) begin
					cmd.mean_wr = 1'b1;
					state_d     = S_OUT;
				end
			end
			S_OUT: begin
				// hold the result until the output register frees up
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/core/tmis_dp.sv
// Datapath: entry store, queue pointers, merge select and interval statistics.
module tmis_dp import tmis_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [QUSE_W-1:0] cfg_wdata,
	input  in_item_t          in_data,
	input  ctrl_cmd_t         cmd,
	output dp_status_t        st,
	output out_item_t         out_data
);

	entry_t             mem_q [SLOTS];
	entry_t             rdata_q;
	entry_t             h0_q;
	in_item_t           item_q;
	logic [QUSE_W-1:0]  quse_q;
	logic [FILL_W-1:0]  fill_q [NUM_QUEUES];
	logic [FILL_W-1:0]  rpos_q [NUM_QUEUES];
	logic [31:0]        prev_q;
	logic [31:0]        cnt_q;
	logic signed [31:0] mean_q;
	logic [30:0]        peak_q;
	logic signed [31:0] delay_q;
	logic [2:0]         status_q;
	logic [QSEL_W-1:0]  from_q;
	logic [31:0]        ostamp_q;
	logic [31:0]        opay_q;
	logic signed [31:0] iv_q;
	logic signed [63:0] prod_s1;
	logic signed [63:0] num_q;
	out_item_t          out_q;

	logic [QUSE_W-1:0]  n_use;
	logic               heads_ok;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ADDR_W-1:0]  wr_addr;
	logic               push_ok;
	logic               best;
	entry_t             pick;
	logic signed [31:0] iv_d;
	logic               div_done;
	logic signed [31:0] div_quo;

	always_comb begin
		n_use = (int'(quse_q) > NUM_QUEUES) ? QUSE_W'(NUM_QUEUES) : quse_q;
		heads_ok = n_use != '0;
		for (int i = 0; i < NUM_QUEUES; i++) begin
			if (i < int'(n_use) && rpos_q[i] >= fill_q[i]) begin
				heads_ok = 1'b0;
			end
		end
	end

	assign st.is_pop    = item_q.func == FUNC_POP;
	assign st.pop_ready = heads_ok;
	assign st.two_q     = int'(n_use) >= 2;
	assign st.div_done  = div_done;

	assign push_ok = int'(item_q.queue_select) < NUM_QUEUES
		&& int'(fill_q[item_q.queue_select]) < QUEUE_DEPTH;
	assign wr_addr = {item_q.queue_select, fill_q[item_q.queue_select][POS_W-1:0]};
	assign rd_addr = cmd.rd_q1 ? {1'b1, rpos_q[1][POS_W-1:0]}
		: {1'b0, rpos_q[0][POS_W-1:0]};

	// lowest queue wins on equal stamps
	assign best = st.two_q && (rdata_q.stamp < h0_q.stamp);
	assign pick = best ? rdata_q : h0_q;
	assign iv_d = (prev_q != '0) ? $signed(pick.stamp - prev_q) : '0;

	always_ff @(posedge clk) begin
		if (cmd.exec_simple && item_q.func == FUNC_PUSH && push_ok) begin
			mem_q[wr_addr] <= '{kind: item_q.is_positioning, stamp: item_q.stamp,
				source_stamp: item_q.source_stamp, payload: item_q.payload};
		end
		if (cmd.rd_q0 || cmd.rd_q1) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quse_q  <= QUEUES_RESET;
			prev_q  <= '0;
			cnt_q   <= '0;
			mean_q  <= '0;
			peak_q  <= '0;
			delay_q <= '0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				fill_q[i] <= '0;
				rpos_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				quse_q <= cfg_wdata;
			end
			if (cmd.exec_simple) begin
				if (item_q.func == FUNC_PUSH && push_ok) begin
					fill_q[item_q.queue_select] <= fill_q[item_q.queue_select] + 1'b1;
				end
				if (item_q.func == FUNC_REWIND) begin
					for (int i = 0; i < NUM_QUEUES; i++) begin
						rpos_q[i] <= '0;
					end
				end
			end
			if (cmd.select) begin
				rpos_q[best] <= rpos_q[best] + 1'b1;
				prev_q       <= pick.stamp;
				// saturate the delivery count
				if (cnt_q != '1) begin
					cnt_q <= cnt_q + 32'd1;
				end
				if (iv_d > $signed({1'b0, peak_q})) begin
					peak_q <= iv_d[30:0];
				end
				if (pick.kind) begin
					delay_q <= $signed(pick.stamp - pick.source_stamp);
				end
			end
			if (cmd.mean_wr) begin
				mean_q <= div_quo;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= '{func: in_data.func, queue_select: in_data.queue_select,
				stamp: in_data.stamp & STAMP_MASK, source_stamp: in_data.source_stamp,
				is_positioning: in_data.is_positioning, payload: in_data.payload};
		end
		if (cmd.cap_h0) begin
			h0_q <= rdata_q;
		end
		if (cmd.exec_simple) begin
			from_q   <= '0;
			ostamp_q <= '0;
			opay_q   <= '0;
			iv_q     <= '0;
			case (item_q.func)
				FUNC_PUSH:   status_q <= push_ok ? STAT_PUSHED : STAT_DROPPED;
				FUNC_REWIND: status_q <= STAT_REWOUND;
				default:     status_q <= STAT_NONE;
			endcase
		end
		if (cmd.select) begin
			status_q <= STAT_DELIVERED;
			from_q   <= best;
			ostamp_q <= pick.stamp;
			opay_q   <= pick.payload;
			iv_q     <= iv_d;
		end
		if (cmd.mul) begin
			prod_s1 <= 64'($signed(mean_q) * $signed({1'b0, cnt_q - 32'd1}));
		end
		if (cmd.num) begin
			num_q <= prod_s1 + {{32{iv_q[31]}}, iv_q};
		end
		if (cmd.load_out) begin
			out_q <= '{status: status_q, from_queue: from_q, out_stamp: ostamp_q,
				out_payload: opay_q, interval: iv_q, mean_interval: mean_q,
				peak_interval: peak_q, fix_delay: delay_q};
		end
	end

	tmis_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (num_q),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_data = out_q;

endmodule
